/* rtl/akft_pkg.sv */
// ----------------------------------------------------------------------------
// akft_pkg
// Shared types and codes for the associative key/flag table: operation
// codes, controller states and the packed request, result and entry types.
// ----------------------------------------------------------------------------
package akft_pkg;

  localparam int unsigned KEY_W = 64;

  // operation codes
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_SET    = 2'd1,
    OP_GET    = 2'd2,
    OP_REMOVE = 2'd3
  } akft_op_t;

  // controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } akft_state_t;

  // request item
  typedef struct packed {
    akft_op_t         op;
    logic [KEY_W-1:0] key;
    logic             value_in;
  } akft_in_t;

  // result item
  typedef struct packed {
    logic ok;
    logic value_out;
  } akft_out_t;

  // one stored entry (the valid mark lives in flops beside the memory)
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             flag;
  } akft_entry_t;

endpackage

/* rtl/assoc_key_flag_table_top.sv */
// ----------------------------------------------------------------------------
// assoc_key_flag_table_top
// Fully associative table of 64-bit keys with a one-bit flag per entry.
// Entries sit in a single-port-read, single-port-write synchronous memory;
// an operation scans it from the lowest entry, one read per cycle.
// ----------------------------------------------------------------------------
// Results: a zero key gives its result in the cycle after the transfer;
//   otherwise entries are read into a register and compared in turn, and a
//   hit or the last entry ends the scan with a registered result.
// Throughput: one operation at a time; start is taken again in the cycle the
//   result strobe shows. The receiver cannot stall.
// Reset: synchronous, active low; all valid marks clear at once, no sweep.
// ----------------------------------------------------------------------------
module assoc_key_flag_table_top
  import akft_pkg::*;
#(
  parameter int unsigned ENTRIES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  akft_in_t  in_data,
  output logic      out_valid,
  output akft_out_t out_data
);

  localparam int unsigned IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W    = $clog2(ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(ENTRIES);

  // entry memory and valid marks
  akft_entry_t        mem [ENTRIES];
  logic [ENTRIES-1:0] valid_r;

  akft_state_t      state_r, state_nxt;
  akft_in_t         req_r;
  logic [CNT_W-1:0] issue_cnt_r;
  logic             rd_pend_r;
  logic [IDX_W-1:0] rd_idx_r;
  akft_entry_t      rd_data_r;
  logic             out_valid_r;
  akft_out_t        out_data_r;

  logic        accept, key_zero, cur_valid, key_eq, hit, last, done;
  logic        rd_en, wr_en, wr_mem;
  akft_entry_t wr_data;

  // compare stage
  assign accept    = start && (state_r == ST_IDLE);
  assign key_zero  = (in_data.key == '0);
  assign cur_valid = valid_r[rd_idx_r];
  assign key_eq    = (rd_data_r.key == req_r.key);
  assign hit       = rd_pend_r && ((req_r.op == OP_ADD) ? (!cur_valid || key_eq)
                                                        : (cur_valid && key_eq));
  assign last      = rd_pend_r && (rd_idx_r == LAST_IDX);
  assign done      = (state_r == ST_SCAN) && (hit || last);
  assign wr_data   = '{key: req_r.key, flag: req_r.value_in};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept && !key_zero) state_nxt = ST_SCAN;
      ST_SCAN: if (done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    busy   = 1'b0;
    rd_en  = 1'b0;
    wr_en  = 1'b0;
    wr_mem = 1'b0;
    unique case (state_r)
      ST_IDLE: busy = 1'b0;
      ST_SCAN: begin
        busy   = 1'b1;
        rd_en  = (issue_cnt_r < CNT_END);
        wr_en  = hit && (req_r.op != OP_GET);
        wr_mem = hit && ((req_r.op == OP_ADD) || (req_r.op == OP_SET));
      end
      default: busy = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= rd_en;
      out_valid_r <= (accept && key_zero) || done;
      if (wr_en) begin
        valid_r[rd_idx_r] <= (req_r.op != OP_REMOVE);
      end
    end
  end

  // request latch, scan counter and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r       <= in_data;
      issue_cnt_r <= '0;
    end else if (rd_en) begin
      issue_cnt_r <= issue_cnt_r + CNT_W'(1);
    end
    if (rd_en) begin
      rd_idx_r <= issue_cnt_r[IDX_W-1:0];
    end
    if (accept && key_zero) begin
      out_data_r <= '{ok: 1'b0, value_out: 1'b0};
    end else if (done) begin
      out_data_r.ok        <= hit;
      out_data_r.value_out <= hit && ((req_r.op == OP_GET) || (req_r.op == OP_REMOVE))
                              && rd_data_r.flag;
    end
  end

  // entry memory: one registered read, one write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[issue_cnt_r[IDX_W-1:0]];
    end
    if (wr_mem) begin
      mem[rd_idx_r] <= wr_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/akft_checker.sv */
// ----------------------------------------------------------------------------
// akft_checker
// Port-level checks on the table's command/result behaviour, bound to the
// top level.
// ----------------------------------------------------------------------------
module akft_checker
  import akft_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input akft_in_t  in_data,
  input logic      out_valid,
  input akft_out_t out_data
);

  // a result strobe never shows while an operation is still in progress
  a_out_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // a zero key fails at once without starting a scan
  a_zero_key: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.key == '0)) |=>
      (out_valid && !out_data.ok && !out_data.value_out && !busy))
    else $error("zero key not rejected in one cycle");

  // a non-zero key transfer starts a scan
  a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.key != '0)) |=> busy)
    else $error("scan did not start");

  // end of a scan always delivers a result
  a_scan_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("scan ended without result");

  // a failed operation never returns a flag
  a_fail_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.ok) |-> !out_data.value_out)
    else $error("flag returned on failure");

endmodule

bind assoc_key_flag_table_top akft_checker u_akft_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the associative key/flag table. A directed pass
// covers zero keys, a full table, update of a held key and duplicate keys;
// a random pass then drives a small key pool with random idle gaps. Each
// result is checked against an in-bench copy of the table contents.
// ----------------------------------------------------------------------------
module tb_top;
  import akft_pkg::*;

  localparam int ENTRIES     = 16;
  localparam int RANDOM_OPS  = 1800;
  localparam int POOL_SIZE   = 24;
  localparam int STALL_LIMIT = 1000;

  // Predicted table contents and the queue of results still to come
  class flag_table_model;
    bit              slot_used [ENTRIES];
    bit [KEY_W-1:0]  slot_key  [ENTRIES];
    bit              slot_flag [ENTRIES];
    akft_out_t       pending_results[$];
    int              errors;

    // apply one accepted operation and queue its result
    function void take_request(akft_in_t req);
      akft_out_t res;
      int        hit;
      int        i;
      res = '0;
      hit = -1;
      if (req.key != '0) begin
        if (req.op == OP_ADD) begin
          // lowest slot that is free or already holds the key
          for (i = 0; i < ENTRIES; i++)
            if (hit < 0 && (!slot_used[i] || slot_key[i] == req.key)) hit = i;
          if (hit >= 0) begin
            slot_used[hit] = 1'b1;
            slot_key[hit]  = req.key;
            slot_flag[hit] = req.value_in;
            res.ok         = 1'b1;
          end
        end else begin
          // lowest valid copy of the key
          for (i = 0; i < ENTRIES; i++)
            if (hit < 0 && slot_used[i] && slot_key[i] == req.key) hit = i;
          if (hit >= 0) begin
            res.ok = 1'b1;
            case (req.op)
              OP_SET: begin
                slot_flag[hit] = req.value_in;
              end
              OP_GET: begin
                res.value_out = slot_flag[hit];
              end
              default: begin
                res.value_out  = slot_flag[hit];
                slot_flag[hit] = 1'b0;
                slot_used[hit] = 1'b0;
              end
            endcase
          end
        end
      end
      pending_results.push_back(res);
    endfunction

    // compare one strobed result with the oldest prediction
    function void check_result(akft_out_t got);
      akft_out_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result ok=%0b value_out=%0b",
                 $time, got.ok, got.value_out);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.ok !== want.ok) begin
          $display("%0t: ok mismatch: expected %0b, got %0b", $time, want.ok, got.ok);
          errors++;
        end
        if (got.value_out !== want.value_out) begin
          $display("%0t: value_out mismatch: expected %0b, got %0b",
                   $time, want.value_out, got.value_out);
          errors++;
        end
      end
    endfunction
  endclass

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  akft_in_t  req_bus = '0;
  logic      busy;
  logic      out_valid;
  akft_out_t out_data;

  flag_table_model flag_table = new;
  bit              no_idle;
  int              stall_cycles;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  assoc_key_flag_table_top #(.ENTRIES(ENTRIES)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (req_bus),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // Monitor: results first, then any request transfer at the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) flag_table.check_result(out_data);
      if (start && !busy) flag_table.take_request(req_bus);
    end
  end

  // Watchdog on cycles with no transfer in either direction
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("** assoc_key_flag_table_top: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Issue one operation, with an optional idle gap beforehand
  task automatic send_op(input akft_op_t op, input logic [KEY_W-1:0] key,
                         input logic val);
    int gap;
    if (!no_idle && $urandom_range(99) < 11) begin
      gap = $urandom_range(1, 20);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    req_bus <= '{op: op, key: key, value_in: val};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    logic [KEY_W-1:0] rkey;
    akft_op_t         rop;
    int               pick;
    int               n;

    foreach (key_pool[i]) begin
      key_pool[i] = {$urandom, $urandom};
      if (key_pool[i] == '0) key_pool[i] = 64'd1;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero key is refused by every operation
    send_op(OP_ADD,    '0, 1'b1);
    send_op(OP_SET,    '0, 1'b1);
    send_op(OP_GET,    '0, 1'b0);
    send_op(OP_REMOVE, '0, 1'b0);

    // fill the table, extremes of the key in the lowest slots
    send_op(OP_ADD, '1,    1'b1);
    send_op(OP_ADD, 64'd1, 1'b0);
    for (n = 0; n < ENTRIES - 2; n++) send_op(OP_ADD, key_pool[n], n[0]);

    // full table: a new key fails, a held key is updated in place
    send_op(OP_ADD, 64'h8000_0000_0000_0000, 1'b1);
    send_op(OP_ADD, '1, 1'b0);

    // free slot 0, then re-add a key held higher up to make a duplicate
    send_op(OP_REMOVE, '1, 1'b0);
    send_op(OP_GET,    '1, 1'b0);
    send_op(OP_ADD,    key_pool[5], 1'b1);
    send_op(OP_SET,    key_pool[5], 1'b0);
    send_op(OP_GET,    key_pool[5], 1'b0);
    send_op(OP_REMOVE, key_pool[5], 1'b0);
    send_op(OP_GET,    key_pool[5], 1'b0);

    // random operations over a small key pool, renewed now and then
    for (n = 0; n < RANDOM_OPS; n++) begin
      no_idle = (n >= 700 && n < 1100);
      if (n % 300 == 299) begin
        foreach (key_pool[i]) begin
          key_pool[i] = {$urandom, $urandom};
          if (key_pool[i] == '0) key_pool[i] = 64'd1;
        end
      end
      pick = $urandom_range(99);
      if (pick < 35)      rop = OP_ADD;
      else if (pick < 50) rop = OP_SET;
      else if (pick < 75) rop = OP_GET;
      else                rop = OP_REMOVE;
      pick = $urandom_range(99);
      if (pick < 4)       rkey = '0;
      else if (pick < 12) rkey = {$urandom, $urandom};
      else                rkey = key_pool[$urandom_range(POOL_SIZE - 1)];
      send_op(rop, rkey, 1'($urandom_range(1)));
    end
    start <= 1'b0;

    // drain outstanding results, then allow for any late strobe
    while (flag_table.pending_results.size() != 0) @(posedge clk);
    repeat (ENTRIES + 4) @(posedge clk);

    if (flag_table.errors == 0 && flag_table.pending_results.size() == 0) begin
      $display("** assoc_key_flag_table_top: PASSED **");
    end else begin
      $display("** assoc_key_flag_table_top: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/akft_pkg.sv
rtl/assoc_key_flag_table_top.sv
rtl/akft_checker.sv
tb/tb_top.sv
